### sv/lmrs_pkg.sv
package lmrs_pkg;

    localparam int ROWS_DEF = 8;
    localparam int COLS_DEF = 6;

    localparam int PERIOD_W = 24;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 24'd125000;
    localparam logic [PERIOD_W-1:0] TICK_MAX = 24'hFFFFFF;

    localparam int S_TDATA_W = 72;
    localparam int M_TDATA_W = 16;
    localparam int STEP_W = 5;

    localparam logic [2:0] ROW_LATCH_ID = 3'd6;
    localparam logic [7:0] ONE_HOT_TOP = 8'h80;
    localparam logic [7:0] FULL_BYTE = 8'hFF;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2,
        OP_FILL  = 2'd3
    } op_t;

endpackage

### sv/led_matrix_row_scanner.sv
// LED matrix row scanner.
// Input stream s_axis_*: one command per transfer. tuser carries the operation
// (tick, write column glyph, clear all, fill all); tdata carries the pixel
// position and eight glyph row bytes.
// Config channel cfg_*: writes the row period in ticks (always ready).
// Output stream m_axis_*: latch writes. A refresh is NUM_COLS + 2 transfers:
// row latch blank, one per column latch, then the one-hot row mask with tlast.
// Write, clear, fill and non-refreshing ticks are accepted and give nothing.
// A refreshing tick holds s_axis_tready low until the row mask is loaded; the
// tick moves the sequencer to ST_EMIT, which then loads the first result into
// the output register. The column sequence is paced by the registered read of
// the frame memory, one column entry per output transfer.
// A stall on m_axis_tready holds the output register and the sequencer;
// the next command is accepted while the final result still waits.
// Reset (aresetn, synchronous) blanks the frame logically via per-column
// valid bits, zeroes the row and tick counters and restores the default
// period. No clearing pass is needed.
module led_matrix_row_scanner #(
    parameter int NUM_ROWS = lmrs_pkg::ROWS_DEF,
    parameter int NUM_COLS = lmrs_pkg::COLS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // x_position[5:0], glyph_row0..glyph_row7 (8 bits each), zero pad
    input  logic [lmrs_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // operation[1:0]
    input  logic [1:0]                     s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // latch_target[2:0], latch_data[7:0], scan_row[2:0], zero pad
    output logic [lmrs_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                           m_axis_tlast,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lmrs_pkg::PERIOD_W-1:0]  cfg_data
);

    localparam int CW = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;
    localparam int RW = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
    localparam int PW = lmrs_pkg::PERIOD_W;
    localparam int SW = lmrs_pkg::STEP_W;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    typedef logic [NUM_ROWS-1:0][7:0] entry_t;

    state_t                state_reg, state_next;
    logic [SW-1:0]         step_reg, step_next;
    logic [2:0]            row_reg, row_next;
    logic [PW-1:0]         elapsed_reg, elapsed_next;
    logic [PW-1:0]         period_reg, period_next;
    logic [NUM_COLS-1:0]   col_valid_reg, col_valid_next;
    logic [7:0]            fill_reg, fill_next;
    logic                  m_valid_reg, m_valid_next;
    logic [2:0]            m_target_reg, m_target_next;
    logic [7:0]            m_data_reg, m_data_next;
    logic [2:0]            m_row_reg, m_row_next;
    logic                  m_last_reg, m_last_next;

    entry_t                mem [NUM_COLS];
    entry_t                mem_q_reg;
    logic                  rd_valid_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [CW-1:0]         mem_waddr;
    logic [CW-1:0]         mem_raddr;
    entry_t                mem_wdata;

    lmrs_pkg::op_t         op;
    logic [4:0]            wr_col;
    logic                  wr_col_ok;
    logic [PW-1:0]         elapsed_inc;
    logic                  refresh;
    logic                  can_load;
    logic                  last_load;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tlast  = m_last_reg;
    assign m_axis_tdata  = {2'b00, m_row_reg, m_data_reg, m_target_reg};

    assign op        = lmrs_pkg::op_t'(s_axis_tuser);
    assign wr_col    = {2'b00, s_axis_tdata[5:3]};
    assign wr_col_ok = (wr_col < 5'(NUM_COLS));
    assign mem_waddr = wr_col[CW-1:0];

    always_comb begin
        for (int r = 0; r < NUM_ROWS; r++) begin
            mem_wdata[r] = s_axis_tdata[6 + 8*r +: 8];
        end
    end

    assign elapsed_inc = (elapsed_reg == lmrs_pkg::TICK_MAX) ? elapsed_reg
                                                             : elapsed_reg + PW'(1);
    assign refresh  = (elapsed_inc >= period_reg);
    assign can_load = !m_valid_reg || m_axis_tready;
    assign last_load = (state_reg == ST_EMIT) && can_load
                       && (step_reg == SW'(NUM_COLS + 1));

    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        row_next       = row_reg;
        elapsed_next   = elapsed_reg;
        period_next    = period_reg;
        col_valid_next = col_valid_reg;
        fill_next      = fill_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_target_next  = m_target_reg;
        m_data_next    = m_data_reg;
        m_row_next     = m_row_reg;
        m_last_next    = m_last_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = step_reg[CW-1:0];

        if (cfg_valid) begin
            period_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    case (op)
                        lmrs_pkg::OP_TICK: begin
                            if (refresh) begin
                                elapsed_next = '0;
                                step_next    = '0;
                                state_next   = ST_EMIT;
                            end else begin
                                elapsed_next = elapsed_inc;
                            end
                        end
                        lmrs_pkg::OP_WRITE: begin
                            if (wr_col_ok) begin
                                mem_we                    = 1'b1;
                                col_valid_next[mem_waddr] = 1'b1;
                            end
                        end
                        lmrs_pkg::OP_CLEAR: begin
                            col_valid_next = '0;
                            fill_next      = '0;
                        end
                        lmrs_pkg::OP_FILL: begin
                            col_valid_next = '0;
                            fill_next      = lmrs_pkg::FULL_BYTE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_row_next   = row_reg;
                    step_next    = step_reg + SW'(1);
                    if (step_reg < SW'(NUM_COLS)) begin
                        mem_re = 1'b1;
                    end
                    if (step_reg == '0) begin
                        m_target_next = lmrs_pkg::ROW_LATCH_ID;
                        m_data_next   = '0;
                        m_last_next   = 1'b0;
                    end else if (step_reg == SW'(NUM_COLS + 1)) begin
                        m_target_next = lmrs_pkg::ROW_LATCH_ID;
                        m_data_next   = lmrs_pkg::ONE_HOT_TOP >> row_reg;
                        m_last_next   = 1'b1;
                        row_next      = (row_reg == 3'(NUM_ROWS - 1)) ? 3'd0
                                                                      : row_reg + 3'd1;
                        state_next    = ST_IDLE;
                    end else begin
                        m_target_next = 3'(step_reg - SW'(1));
                        m_data_next   = rd_valid_reg ? mem_q_reg[row_reg[RW-1:0]]
                                                     : fill_reg;
                        m_last_next   = 1'b0;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            row_reg       <= '0;
            elapsed_reg   <= '0;
            period_reg    <= lmrs_pkg::PERIOD_RESET;
            col_valid_reg <= '0;
            fill_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            row_reg       <= row_next;
            elapsed_reg   <= elapsed_next;
            period_reg    <= period_next;
            col_valid_reg <= col_valid_next;
            fill_reg      <= fill_next;
            m_valid_reg   <= m_valid_next;
        end
        m_target_reg <= m_target_next;
        m_data_reg   <= m_data_next;
        m_row_reg    <= m_row_next;
        m_last_reg   <= m_last_next;
    end

    // frame memory: one entry per column, all rows of that column
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            mem_q_reg    <= mem[mem_raddr];
            rd_valid_reg <= col_valid_reg[mem_raddr];
        end
    end

    property p_last_is_row_latch;
        @(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> (m_target_reg == lmrs_pkg::ROW_LATCH_ID);
    endproperty
    a_last_is_row_latch: assert property (p_last_is_row_latch)
        else $error("tlast on a write that is not the row latch");

    property p_step_range;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) |-> (step_reg <= SW'(NUM_COLS + 1));
    endproperty
    a_step_range: assert property (p_step_range)
        else $error("refresh sequencer ran past the row mask");

    property p_refresh_restarts_timer;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) && s_axis_tvalid && (op == lmrs_pkg::OP_TICK) && refresh
        |=> (elapsed_reg == '0) && (state_reg == ST_EMIT) && (step_reg == '0);
    endproperty
    a_refresh_restarts_timer: assert property (p_refresh_restarts_timer)
        else $error("refresh tick did not restart timer and sequencer");

    property p_row_advances;
        @(posedge aclk) disable iff (!aresetn)
        last_load |=> (row_reg == (($past(row_reg) == 3'(NUM_ROWS - 1)) ? 3'd0
                                   : $past(row_reg) + 3'd1));
    endproperty
    a_row_advances: assert property (p_row_advances)
        else $error("row did not advance after the row mask");

    property p_emit_holds_on_stall;
        @(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT) && m_valid_reg && !m_axis_tready |=> $stable(step_reg);
    endproperty
    a_emit_holds_on_stall: assert property (p_emit_holds_on_stall)
        else $error("sequencer moved while output stalled");

endmodule
